[design/lcfs_pkg.sv]
// Package for the LED cube framebuffer scanner.
// Holds item structs, opcodes, the controller state type and the store request.
// No dependencies.
package lcfs_pkg;

  localparam int LAYERS_DEFAULT = 4;
  localparam int LAYERS_MAX     = 8;
  localparam int ROW_ADDR_W     = 3;   // enough for LAYERS_MAX rows
  localparam int ROW_W          = 16;  // two frame bytes per layer
  localparam int DRIVE_W        = 4;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET       = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_SET_ALL   = 3'd4;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [7:0] coord_x;
    logic signed [7:0] coord_y;
    logic signed [7:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         row_byte_first;
    logic [7:0]         row_byte_second;
    logic [DRIVE_W-1:0] column_drive;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    logic                  rd_en;
    logic [ROW_ADDR_W-1:0] rd_row;
    logic                  wr_en;
    logic [ROW_ADDR_W-1:0] wr_row;
    logic [ROW_W-1:0]      wr_data;
    logic                  fill_en;
    logic                  fill_ones;
  } store_req_t;

endpackage

[design/lcfs_store.sv]
// Frame store: one 16-bit row per layer, with a registered (synchronous) read.
// Per-row valid bits and a fill value give clear-all and set-all without writing each row.
// Depends on lcfs_pkg.
module lcfs_store #(
  parameter int LAYERS = lcfs_pkg::LAYERS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lcfs_pkg::store_req_t    req,
  output logic [lcfs_pkg::ROW_W-1:0] rd_data
);

  localparam int RW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  logic [lcfs_pkg::ROW_W-1:0] mem [LAYERS];
  logic [LAYERS-1:0]          row_valid;
  logic                       fill_ones;
  logic [lcfs_pkg::ROW_W-1:0] rd_raw;
  logic                       rd_hit;
  logic                       rd_fill;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row[RW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw  <= mem[req.rd_row[RW-1:0]];
      rd_hit  <= row_valid[req.rd_row[RW-1:0]];
      rd_fill <= fill_ones;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fill_ones <= 1'b0;
    end else if (req.fill_en) begin
      row_valid <= '0;
      fill_ones <= req.fill_ones;
    end else if (req.wr_en) begin
      row_valid[req.wr_row[RW-1:0]] <= 1'b1;
    end
  end

  // rows not written since the last fill read as the fill pattern
  assign rd_data = rd_hit ? rd_raw : {lcfs_pkg::ROW_W{rd_fill}};

  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.rd_en && req.wr_en))
    else $error("store read and write in the same cycle");

  a_no_fill_during_access: assert property (@(posedge clk) disable iff (rst)
    !(req.fill_en && (req.wr_en || req.rd_en)))
    else $error("fill overlaps a row access");

  a_fill_drops_rows: assert property (@(posedge clk) disable iff (rst)
    req.fill_en |=> (row_valid == '0))
    else $error("rows still valid after fill");

endmodule

[design/led_cube_framebuffer_scan.sv]
// Framebuffer and column scanner of a 4x4x4 LED cube. In-range set/clear pixel
// items and scan ticks pass through IDLE and MODIFY (store read, then modify/write
// or result load); clear-all, set-all, pixel items with an out-of-range coordinate
// and unused opcodes finish in IDLE. The registered read of the frame store is
// why reads need MODIFY. A tick whose result register is still full and stalled
// holds until the result is taken. No clearing pass after reset.
module led_cube_framebuffer_scan #(
  parameter int LAYERS = lcfs_pkg::LAYERS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  lcfs_pkg::in_item_t  item,
  input  logic                item_valid,
  output logic                item_stall,
  output lcfs_pkg::out_item_t result,
  output logic                result_valid,
  input  logic                result_stall
);

  localparam int RW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  lcfs_pkg::state_t     state, state_next;
  lcfs_pkg::store_req_t req;
  logic [lcfs_pkg::ROW_W-1:0] rd_data;

  logic          item_fire;
  logic          coord_ok;
  logic          pixel_op;
  logic          needs_read;
  logic          out_load;
  logic          col_advance;
  logic [RW-1:0] scan_column;
  logic          cur_tick;
  logic          cur_set;
  logic [3:0]    cur_bit;
  logic [RW-1:0] cur_row;
  logic [lcfs_pkg::ROW_W-1:0] bit_mask;
  logic [lcfs_pkg::DRIVE_W-1:0] drive;

  lcfs_store #(.LAYERS(LAYERS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign item_stall = (state != lcfs_pkg::ST_IDLE);
  assign item_fire  = item_valid && !item_stall;

  assign coord_ok = (item.coord_x[7:2] == '0) && (item.coord_y[7:2] == '0)
                    && !item.coord_z[7] && ($unsigned(item.coord_z) < 8'(LAYERS));
  assign pixel_op = (item.opcode == lcfs_pkg::OP_SET) || (item.opcode == lcfs_pkg::OP_CLEAR);
  assign needs_read = (item.opcode == lcfs_pkg::OP_TICK) || (pixel_op && coord_ok);

  assign bit_mask = lcfs_pkg::ROW_W'(1) << cur_bit;
  assign drive = (32'(scan_column) < lcfs_pkg::DRIVE_W) ?
                 (lcfs_pkg::DRIVE_W'(1) << scan_column) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    req           = '0;
    out_load      = 1'b0;
    col_advance   = 1'b0;
    unique case (state)
      lcfs_pkg::ST_IDLE: begin
        if (item_fire) begin
          if (needs_read) begin
            req.rd_en  = 1'b1;
            req.rd_row = (item.opcode == lcfs_pkg::OP_TICK) ?
                         lcfs_pkg::ROW_ADDR_W'(scan_column) :
                         lcfs_pkg::ROW_ADDR_W'(item.coord_z[RW-1:0]);
            state_next = lcfs_pkg::ST_MODIFY;
          end else if (item.opcode == lcfs_pkg::OP_CLEAR_ALL ||
                       item.opcode == lcfs_pkg::OP_SET_ALL) begin
            req.fill_en   = 1'b1;
            req.fill_ones = (item.opcode == lcfs_pkg::OP_SET_ALL);
          end
        end
      end
      lcfs_pkg::ST_MODIFY: begin
        if (cur_tick) begin
          // hold until the result register can take the transfer
          if (!result_valid || !result_stall) begin
            out_load    = 1'b1;
            col_advance = 1'b1;
            state_next  = lcfs_pkg::ST_IDLE;
          end
        end else begin
          req.wr_en   = 1'b1;
          req.wr_row  = lcfs_pkg::ROW_ADDR_W'(cur_row);
          req.wr_data = cur_set ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
          state_next  = lcfs_pkg::ST_IDLE;
        end
      end
      default: state_next = lcfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_fire && needs_read) begin
      cur_tick <= (item.opcode == lcfs_pkg::OP_TICK);
      cur_set  <= (item.opcode == lcfs_pkg::OP_SET);
      cur_bit  <= {item.coord_y[1:0], item.coord_x[1:0]};
      cur_row  <= item.coord_z[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= '0;
    end else if (col_advance) begin
      scan_column <= (scan_column == RW'(LAYERS - 1)) ? '0 : scan_column + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.row_byte_first  <= rd_data[7:0];
      result.row_byte_second <= rd_data[15:8];
      result.column_drive    <= drive;
    end
  end

  a_tick_goes_modify: assert property (@(posedge clk) disable iff (rst)
    (item_fire && item.opcode == lcfs_pkg::OP_TICK) |=> (state == lcfs_pkg::ST_MODIFY))
    else $error("tick did not start a store read");

  a_pixel_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (state == lcfs_pkg::ST_MODIFY && !cur_tick) |=> (state == lcfs_pkg::ST_IDLE))
    else $error("pixel write took more than one modify cycle");

  a_column_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(scan_column))
    else $error("scan column moved without a result");

endmodule

[test/testbench.sv]
// Self-checking testbench for led_cube_framebuffer_scan: directed and random pixel,
// fill and scan-tick transfers, each scan result checked against a local framebuffer.
// Depends on lcfs_pkg and the led_cube_framebuffer_scan RTL.
module testbench;

  localparam int LAYERS = lcfs_pkg::LAYERS_DEFAULT;
  localparam int SIDE = 4;
  localparam int FRAME_BYTES = 2 * LAYERS;
  localparam int HOLD_CYCLES = 200;
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  class cube_scoreboard;
    logic [7:0] frame [FRAME_BYTES];
    int column;
    lcfs_pkg::out_item_t scan_rows_q[$];
    int errors;
    int items_noted;
    int scans_checked;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      column = 0;
      errors = 0;
      items_noted = 0;
      scans_checked = 0;
    endfunction

    // Update the local framebuffer and queue the row a tick will show.
    function void note_item(lcfs_pkg::in_item_t it);
      int x, y, z, idx;
      lcfs_pkg::out_item_t row;
      x = it.coord_x;
      y = it.coord_y;
      z = it.coord_z;
      items_noted++;
      case (it.opcode)
        lcfs_pkg::OP_TICK: begin
          row.row_byte_first = frame[2 * column];
          row.row_byte_second = frame[2 * column + 1];
          row.column_drive = (column < lcfs_pkg::DRIVE_W) ?
                             lcfs_pkg::DRIVE_W'(1 << column) : '0;
          scan_rows_q.push_back(row);
          column = (column + 1 >= LAYERS) ? 0 : column + 1;
        end
        lcfs_pkg::OP_SET, lcfs_pkg::OP_CLEAR: begin
          if (x >= 0 && y >= 0 && z >= 0 && x < SIDE && y < SIDE && z < LAYERS) begin
            idx = z * 2 + y / 2;
            frame[idx][x + 4 * (y % 2)] = (it.opcode == lcfs_pkg::OP_SET);
          end
        end
        lcfs_pkg::OP_CLEAR_ALL: foreach (frame[i]) frame[i] = 8'h00;
        lcfs_pkg::OP_SET_ALL: foreach (frame[i]) frame[i] = 8'hff;
        default: ;
      endcase
    endfunction

    function void check_scan(lcfs_pkg::out_item_t got);
      lcfs_pkg::out_item_t want;
      if (scan_rows_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h %h %h", $time,
                 got.row_byte_first, got.row_byte_second, got.column_drive);
        errors++;
        return;
      end
      want = scan_rows_q.pop_front();
      scans_checked++;
      if (got.row_byte_first !== want.row_byte_first) begin
        $display("%0t: row_byte_first expected %h actual %h", $time,
                 want.row_byte_first, got.row_byte_first);
        errors++;
      end
      if (got.row_byte_second !== want.row_byte_second) begin
        $display("%0t: row_byte_second expected %h actual %h", $time,
                 want.row_byte_second, got.row_byte_second);
        errors++;
      end
      if (got.column_drive !== want.column_drive) begin
        $display("%0t: column_drive expected %h actual %h", $time,
                 want.column_drive, got.column_drive);
        errors++;
      end
    endfunction

    function int pending();
      return scan_rows_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  lcfs_pkg::in_item_t item;
  logic item_valid;
  logic item_stall;
  lcfs_pkg::out_item_t result;
  logic result_valid;
  logic result_stall;

  logic quiet_tx;
  logic quiet_rx;
  logic hold_rx;
  logic hold_done;
  int hold_count;

  cube_scoreboard sb = new();

  led_cube_framebuffer_scan #(.LAYERS(LAYERS)) uut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .result(result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("led_cube_framebuffer_scan: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_scan(result);
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    result_stall <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx && !hold_done) begin
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end
      result_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  // Offer one item, hold it until the transfer, then sometimes drop item_valid before returning.
  task automatic send_op(logic [2:0] op, logic [7:0] x, logic [7:0] y, logic [7:0] z);
    lcfs_pkg::in_item_t it;
    it.opcode = op;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (!quiet_tx && $urandom_range(99) < 35) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  initial begin
    logic [2:0] op;
    logic [7:0] x, y, z;
    int r;
    rst <= 1'b1;
    item <= '0;
    item_valid <= 1'b0;
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    hold_rx = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pixel corners, out-of-range coordinates, unused opcodes, fills, wrap.
    send_op(lcfs_pkg::OP_SET, 8'd0, 8'd0, 8'd0);
    send_op(lcfs_pkg::OP_SET, 8'd3, 8'd3, 8'd3);
    send_op(lcfs_pkg::OP_SET, 8'd1, 8'd1, 8'd1);
    send_op(lcfs_pkg::OP_SET, 8'hff, 8'd0, 8'd0);
    send_op(lcfs_pkg::OP_SET, 8'd4, 8'd0, 8'd0);
    send_op(lcfs_pkg::OP_SET, 8'd0, 8'd127, 8'd0);
    send_op(lcfs_pkg::OP_SET, 8'd0, 8'd0, 8'd4);
    send_op(lcfs_pkg::OP_SET, 8'd0, 8'd0, 8'h80);
    send_op(lcfs_pkg::OP_CLEAR, 8'd3, 8'd3, 8'd3);
    send_op(lcfs_pkg::OP_CLEAR, 8'd0, 8'hff, 8'd0);
    send_op(OP_UNUSED_LO, 8'd1, 8'd1, 8'd1);
    send_op(OP_UNUSED_MID, 8'd2, 8'd2, 8'd2);
    send_op(OP_UNUSED_HI, 8'h7f, 8'h80, 8'hff);
    repeat (4) send_op(lcfs_pkg::OP_TICK, 8'h80, 8'h7f, 8'h55);
    send_op(lcfs_pkg::OP_SET_ALL, 8'd0, 8'd0, 8'd0);
    send_op(lcfs_pkg::OP_CLEAR, 8'd0, 8'd2, 8'd3);
    repeat (4) send_op(lcfs_pkg::OP_TICK, 8'd0, 8'd0, 8'd0);
    send_op(lcfs_pkg::OP_CLEAR_ALL, 8'hff, 8'hff, 8'hff);
    send_op(lcfs_pkg::OP_TICK, 8'd0, 8'd0, 8'd0);

    for (int i = 0; i < 400; i++) begin
      if (i == 100) hold_rx = 1'b1;
      if (i == 200) begin
        item_valid <= 1'b0;
        // let the monitor note the last transfer before counting what is owed
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      quiet_tx = (i >= 250 && i < 330);
      quiet_rx = quiet_tx;
      r = $urandom_range(99);
      if (r < 35) op = lcfs_pkg::OP_TICK;
      else if (r < 60) op = lcfs_pkg::OP_SET;
      else if (r < 82) op = lcfs_pkg::OP_CLEAR;
      else if (r < 86) op = lcfs_pkg::OP_CLEAR_ALL;
      else if (r < 90) op = lcfs_pkg::OP_SET_ALL;
      else op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      if ($urandom_range(9) < 8) begin
        x = 8'($urandom_range(SIDE - 1));
        y = 8'($urandom_range(SIDE - 1));
        z = 8'($urandom_range(LAYERS - 1));
      end else begin
        x = 8'($urandom);
        y = 8'($urandom);
        z = 8'($urandom);
      end
      send_op(op, x, y, z);
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    item_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d input transfers and %0d scan results, with fills, pixel edits,",
             sb.items_noted, sb.scans_checked);
    $display("out-of-range and unused items, a long result hold-off and a full drain pause");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("led_cube_framebuffer_scan: match");
    end else begin
      $display("led_cube_framebuffer_scan: mismatch");
    end
    $finish;
  end
endmodule
